// ===== hdl/fce_pkg.sv =====
// ----------------------------------------------------------------------------
// fce_pkg - shared definitions for the FAT12 cluster chain engine
// Field widths, FAT12 marker values, request kinds and sequencer states.
// ----------------------------------------------------------------------------
package fce_pkg;

   // Field widths
   localparam int ENTRY_W   = 12;   // one FAT12 entry / cluster number
   localparam int LIMIT_W   = 13;   // allocation limit, holds 4096
   localparam int KIND_W    = 2;
   localparam int MASK_BITS = 12;   // sectors reported in the mask

   // FAT12 marker values
   localparam logic [ENTRY_W-1:0] END_MARK      = 12'hFFF;
   localparam logic [ENTRY_W-1:0] CHAIN_END_MIN = 12'hFF0;
   localparam logic [ENTRY_W-1:0] FREE_ENTRY    = 12'h000;
   localparam logic [ENTRY_W-1:0] FIRST_DATA_CL = 12'd2;

   // Register reset and parameter defaults
   localparam logic [LIMIT_W-1:0] RESET_ALLOC_LIMIT = 13'd2880;
   localparam int DEF_NUM_ENTRIES  = 4096;
   localparam int DEF_SECTOR_BYTES = 512;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_ALLOC = 2'd2,
      KIND_FREE  = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,      // zero the table after reset
      ST_IDLE,       // wait for a request word
      ST_DISPATCH,   // decode request
      ST_RDATA,      // read data returns
      ST_ASCAN,      // allocation: bound check, issue read
      ST_ACHK,       // allocation: test entry
      ST_FCHK,       // free: end check, issue read
      ST_FWR,        // free: zero entry, follow link
      ST_DONE        // hand result to output register
   } state_type;

endpackage

// ===== hdl/fce_ram.sv =====
// ----------------------------------------------------------------------------
// fce_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fce_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fce_sector.sv =====
// ----------------------------------------------------------------------------
// fce_sector - FAT sector touch mask for one cluster
// Entry c sits at packed byte c/2*3 + (c&1) and the byte after it; the
// mask flags the sectors holding those two bytes (sectors 0..11 only).
// ----------------------------------------------------------------------------
module fce_sector #(
   parameter int SECTOR_BYTES = fce_pkg::DEF_SECTOR_BYTES
) (
   input  logic [fce_pkg::ENTRY_W-1:0]   cluster,
   output logic [fce_pkg::MASK_BITS-1:0] sector_bits
);

   localparam int BOUND_W = 17;   // holds MASK_BITS * 4096

   logic [fce_pkg::ENTRY_W-1:0] half_cl;
   logic [BOUND_W-1:0]          byte_lo;
   logic [BOUND_W-1:0]          byte_hi;

   // byte offset = half*3 + odd bit
   assign half_cl = cluster >> 1;
   assign byte_lo = BOUND_W'(half_cl) + (BOUND_W'(half_cl) << 1)
                    + BOUND_W'(cluster[0]);
   assign byte_hi = byte_lo + BOUND_W'(1);

   // One range compare per reported sector
   for (genvar i = 0; i < fce_pkg::MASK_BITS; i++) begin : g_sec
      localparam logic [BOUND_W-1:0] SEC_LO = BOUND_W'(i * SECTOR_BYTES);
      localparam logic [BOUND_W-1:0] SEC_HI = BOUND_W'((i + 1) * SECTOR_BYTES);
      assign sector_bits[i] = ((byte_lo >= SEC_LO) && (byte_lo < SEC_HI)) ||
                              ((byte_hi >= SEC_LO) && (byte_hi < SEC_HI));
   end

endmodule

// ===== hdl/fat12_cluster_chain_engine.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_engine - FAT12 allocation table engine
// Holds the table in RAM and serves read, write, allocate and free-chain
// requests with a small sequencer around one RAM port pair.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  req     | req_valid/req_stall, kind, cluster, value  | in
//  rsp     | rsp_valid/rsp_stall, entry, ok, sector_mask| out
//  csr     | csr_wr_en, csr_wr_data (alloc_limit)       | in
//
// A write goes from accept through dispatch to done; a read also waits for its
// registered RAM data. Allocation takes one step per entry scanned and fails
// when the scan runs out; free chain takes one step per entry freed and stops
// at once when the start is below two. Each table step is one RAM read with
// its registered data, then a test or a write. After reset a clearing pass
// zeroes the table with req_stall high; csr writes are taken at any time.
// A result word waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_engine #(
   parameter int NUM_ENTRIES  = fce_pkg::DEF_NUM_ENTRIES,
   parameter int SECTOR_BYTES = fce_pkg::DEF_SECTOR_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fce_pkg::KIND_W-1:0]    req_kind,
   input  logic [fce_pkg::ENTRY_W-1:0]   req_cluster,
   input  logic [fce_pkg::ENTRY_W-1:0]   req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fce_pkg::ENTRY_W-1:0]   rsp_entry,
   output logic                          rsp_ok,
   output logic [fce_pkg::MASK_BITS-1:0] rsp_sector_mask,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [fce_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int SW = $clog2(NUM_ENTRIES + 1);
   localparam int EW = fce_pkg::ENTRY_W;
   localparam int LW = fce_pkg::LIMIT_W;
   localparam int MW = fce_pkg::MASK_BITS;
   localparam logic [LW-1:0] N_LIM  = LW'(NUM_ENTRIES);
   localparam logic [LW-1:0] N_LAST = LW'(NUM_ENTRIES - 1);
   localparam logic [SW-1:0] N_STEP = SW'(NUM_ENTRIES);

   // Registers
   fce_pkg::state_type state_ff, state_in;
   fce_pkg::kind_type  kind_ff, kind_in;
   logic [EW-1:0] cl_ff, cl_in;
   logic [EW-1:0] val_ff, val_in;
   logic [LW-1:0] idx_ff, idx_in;       // clear / allocation index
   logic [LW-1:0] top_ff, top_in;       // allocation bound
   logic [EW-1:0] cur_ff, cur_in;       // free walk cluster
   logic [SW-1:0] steps_ff, steps_in;
   logic [EW-1:0] wentry_ff, wentry_in;
   logic          wok_ff, wok_in;
   logic [MW-1:0] wmask_ff, wmask_in;
   logic [LW-1:0] limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0] rsp_entry_ff, rsp_entry_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [MW-1:0] rsp_mask_ff, rsp_mask_in;

   // RAM and sector unit wiring
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;
   logic [MW-1:0] cur_sectors;
   logic          req_accept;
   logic          out_free;

   fce_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   fce_sector #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_sector (
      .cluster     (cur_ff),
      .sector_bits (cur_sectors)
   );

   assign req_stall  = (state_ff != fce_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= fce_pkg::RESET_ALLOC_LIMIT;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Sequencer state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fce_pkg::ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      cl_ff        <= cl_in;
      val_ff       <= val_in;
      top_ff       <= top_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      wentry_ff    <= wentry_in;
      wok_ff       <= wok_in;
      wmask_ff     <= wmask_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cl_in        = cl_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      wentry_in    = wentry_ff;
      wok_in       = wok_ff;
      wmask_in     = wmask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_entry_in = rsp_entry_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_mask_in  = rsp_mask_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = fce_pkg::FREE_ENTRY;
      ram_raddr    = cl_ff[AW-1:0];

      unique case (state_ff)
         // Zero one entry per cycle
         fce_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == N_LAST) begin
               state_in = fce_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + LW'(1);
            end
         end

         fce_pkg::ST_IDLE: begin
            if (req_accept) begin
               kind_in  = fce_pkg::kind_type'(req_kind);
               cl_in    = req_cluster;
               val_in   = req_value;
               state_in = fce_pkg::ST_DISPATCH;
            end
         end

         fce_pkg::ST_DISPATCH: begin
            wentry_in = '0;
            wok_in    = 1'b1;
            wmask_in  = '0;
            unique case (kind_ff)
               fce_pkg::KIND_READ: begin
                  state_in = fce_pkg::ST_RDATA;
               end
               fce_pkg::KIND_WRITE: begin
                  ram_we    = ({1'b0, cl_ff} < N_LIM);
                  ram_waddr = cl_ff[AW-1:0];
                  ram_wdata = val_ff;
                  state_in  = fce_pkg::ST_DONE;
               end
               fce_pkg::KIND_ALLOC: begin
                  idx_in   = LW'(fce_pkg::FIRST_DATA_CL);
                  top_in   = (limit_ff > N_LIM) ? N_LIM : limit_ff;
                  state_in = fce_pkg::ST_ASCAN;
               end
               fce_pkg::KIND_FREE: begin
                  cur_in   = cl_ff;
                  steps_in = '0;
                  state_in = (cl_ff < fce_pkg::FIRST_DATA_CL) ? fce_pkg::ST_DONE
                                                               : fce_pkg::ST_FCHK;
               end
               default: begin
                  state_in = fce_pkg::ST_DONE;
               end
            endcase
         end

         // Read data from the address issued in dispatch
         fce_pkg::ST_RDATA: begin
            wentry_in = ({1'b0, cl_ff} < N_LIM) ? ram_rdata : '0;
            state_in  = fce_pkg::ST_DONE;
         end

         // Allocation scan: bound check and read
         fce_pkg::ST_ASCAN: begin
            ram_raddr = idx_ff[AW-1:0];
            if (idx_ff >= top_ff) begin
               wok_in   = 1'b0;
               state_in = fce_pkg::ST_DONE;
            end else begin
               state_in = fce_pkg::ST_ACHK;
            end
         end

         fce_pkg::ST_ACHK: begin
            if (ram_rdata == fce_pkg::FREE_ENTRY) begin
               ram_we    = 1'b1;
               ram_wdata = fce_pkg::END_MARK;
               wentry_in = idx_ff[EW-1:0];
               state_in  = fce_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = fce_pkg::ST_ASCAN;
            end
         end

         // Free walk: stop at end mark, off-table link or step budget
         fce_pkg::ST_FCHK: begin
            ram_raddr = cur_ff[AW-1:0];
            if ((cur_ff >= fce_pkg::CHAIN_END_MIN) || ({1'b0, cur_ff} >= N_LIM)) begin
               state_in = fce_pkg::ST_DONE;
            end else if (steps_ff == N_STEP) begin
               wok_in   = 1'b0;
               state_in = fce_pkg::ST_DONE;
            end else begin
               state_in = fce_pkg::ST_FWR;
            end
         end

         fce_pkg::ST_FWR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff[AW-1:0];
            wmask_in  = wmask_ff | cur_sectors;
            steps_in  = steps_ff + SW'(1);
            cur_in    = ram_rdata;
            state_in  = fce_pkg::ST_FCHK;
         end

         // Load the output register once it is free
         fce_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = wentry_ff;
               rsp_ok_in    = wok_ff;
               rsp_mask_in  = wmask_ff;
               state_in     = fce_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fce_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry       = rsp_entry_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_sector_mask = rsp_mask_ff;

   // Assertions
   a_new_word_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == fce_pkg::ST_DONE))
      else $error("response word appeared without a finished request");

   a_fail_has_no_entry : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_entry == '0))
      else $error("failed request returned a nonzero entry");

   a_alloc_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fce_pkg::ST_ACHK) |->
         (idx_ff >= LW'(fce_pkg::FIRST_DATA_CL)) && (idx_ff < top_ff))
      else $error("allocation index outside scan range");

   a_step_budget : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fce_pkg::ST_FWR) |-> (steps_ff < N_STEP))
      else $error("free walk exceeded its step budget");

endmodule

// ===== dv/tb_fat12_cluster_chain_engine.sv =====
// ----------------------------------------------------------------------------
// tb_fat12_cluster_chain_engine - self-checking bench for the FAT12 engine
// Walks a short table of directed requests, then several phases of random
// traffic under different allocation limits. Random traffic is mostly
// well-formed cluster chains that are built and then freed, with allocation,
// reads and raw noise mixed in. A shadow copy of the table predicts each result
// word the directed rows do not fix; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fat12_cluster_chain_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import fce_pkg::*;

   localparam int NUM_ENT       = DEF_NUM_ENTRIES;
   localparam int SEC_BYTES     = DEF_SECTOR_BYTES;
   localparam int NUM_PHASES    = 4;
   localparam int PHASE_ITEMS   = 350;
   localparam int CALM_ITEMS    = 150;    // no idling at the tail of the run
   localparam int LONG_HOLD     = 400;    // receiver back-pressure stretch
   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_CYCLES    = 3_000_000;
   localparam int NUM_DIRECTED  = 28;

   typedef struct packed {
      logic [ENTRY_W-1:0]   entry;
      logic                 ok;
      logic [MASK_BITS-1:0] sector_mask;
   } fat_result_type;

   // one directed step: either a csr write (data = limit) or a request word
   typedef struct packed {
      logic               is_cfg;
      kind_type           kind;
      logic [ENTRY_W-1:0] cluster;
      logic [LIMIT_W-1:0] data;
      logic               typed;    // use the literal result below
      fat_result_type     want;
   } directed_row_type;

   localparam fat_result_type PLAIN_OK = '{FREE_ENTRY, 1'b1, 12'h000};

   // columns: is_cfg, kind, cluster, data, typed, {entry, ok, sector_mask}
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      // fresh table reads back zero at both ends
      '{1'b0, KIND_READ,  12'h000, 13'h0000, 1'b1, PLAIN_OK},
      '{1'b0, KIND_READ,  12'hFFF, 13'h0000, 1'b1, PLAIN_OK},
      // first allocations take clusters 2 and 3
      '{1'b0, KIND_ALLOC, 12'h000, 13'h0000, 1'b1, '{12'h002, 1'b1, 12'h000}},
      '{1'b0, KIND_ALLOC, 12'hFFF, 13'h0FFF, 1'b1, '{12'h003, 1'b1, 12'h000}},
      '{1'b0, KIND_READ,  12'h002, 13'h0000, 1'b1, '{12'hFFF, 1'b1, 12'h000}},
      '{1'b0, KIND_WRITE, 12'hFFF, 13'h0FFF, 1'b1, PLAIN_OK},
      '{1'b0, KIND_READ,  12'hFFF, 13'h0000, 1'b1, '{12'hFFF, 1'b1, 12'h000}},
      // reserved entries hold end marks
      '{1'b0, KIND_WRITE, 12'h000, 13'h0FF8, 1'b1, PLAIN_OK},
      '{1'b0, KIND_WRITE, 12'h001, 13'h0FFF, 1'b1, PLAIN_OK},
      // starts below two or at an end mark free nothing
      '{1'b0, KIND_FREE,  12'h000, 13'h0000, 1'b1, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'h001, 13'h0000, 1'b1, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'hFF0, 13'h0000, 1'b1, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'hFFF, 13'h0000, 1'b1, PLAIN_OK},
      // entry 341 straddles the sector 0/1 boundary
      '{1'b0, KIND_WRITE, 12'h155, 13'h0FFF, 1'b1, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'h155, 13'h0000, 1'b1, '{12'h000, 1'b1, 12'h003}},
      // top sector of the mask
      '{1'b0, KIND_WRITE, 12'hEEE, 13'h0FF0, 1'b1, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'hEEE, 13'h0000, 1'b1, '{12'h000, 1'b1, 12'h800}},
      // two-link chain
      '{1'b0, KIND_WRITE, 12'h00A, 13'h000B, 1'b0, PLAIN_OK},
      '{1'b0, KIND_WRITE, 12'h00B, 13'h0FF7, 1'b0, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'h00A, 13'h0000, 1'b1, '{12'h000, 1'b1, 12'h001}},
      // chain runs into cluster 0, which links to itself: walk gives up
      '{1'b0, KIND_WRITE, 12'h000, 13'h0000, 1'b0, PLAIN_OK},
      '{1'b0, KIND_WRITE, 12'h005, 13'h0000, 1'b0, PLAIN_OK},
      '{1'b0, KIND_FREE,  12'h005, 13'h0000, 1'b1, '{12'h000, 1'b0, 12'h001}},
      '{1'b0, KIND_WRITE, 12'h000, 13'h0FF8, 1'b0, PLAIN_OK},
      // smallest limit: only cluster 2 searched and it is taken
      '{1'b1, KIND_READ,  12'h000, 13'd3,    1'b0, PLAIN_OK},
      '{1'b0, KIND_ALLOC, 12'h000, 13'h0000, 1'b1, '{12'h000, 1'b0, 12'h000}},
      // largest limit
      '{1'b1, KIND_READ,  12'h000, 13'd4096, 1'b0, PLAIN_OK},
      '{1'b0, KIND_ALLOC, 12'h2AA, 13'h0555, 1'b0, PLAIN_OK}
   };

   // DUT interface
   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   kind_type             req_kind        = KIND_READ;
   logic [ENTRY_W-1:0]   req_cluster     = '0;
   logic [ENTRY_W-1:0]   req_value       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [ENTRY_W-1:0]   rsp_entry;
   logic                 rsp_ok;
   logic [MASK_BITS-1:0] rsp_sector_mask;
   logic                 csr_wr_en       = 1'b0;
   logic [LIMIT_W-1:0]   csr_wr_data     = '0;

   // shadow state and scoreboard
   bit   [ENTRY_W-1:0]   fat_shadow [NUM_ENT];
   logic [LIMIT_W-1:0]   limit_shadow    = RESET_ALLOC_LIMIT;
   fat_result_type       pending_results [$];
   logic [ENTRY_W-1:0]   owned_clusters [$];
   int                   loop_budget     = 5;   // walks that run out of steps
   int                   errors          = 0;
   int                   cycles          = 0;
   logic                 calm            = 1'b0;
   logic                 hold_token      = 1'b0;
   logic                 hold_taken      = 1'b0;
   int                   stall_left      = 0;

   fat12_cluster_chain_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_cluster     (req_cluster),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry       (rsp_entry),
      .rsp_ok          (rsp_ok),
      .rsp_sector_mask (rsp_sector_mask),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // sectors hit by the two bytes of packed entry c
   function automatic logic [MASK_BITS-1:0] sectors_touched(int c);
      int                   first_byte;
      logic [MASK_BITS-1:0] m;
      first_byte = (c / 2) * 3 + (c % 2);
      m = '0;
      for (int b = first_byte; b <= first_byte + 1; b++)
         if (b / SEC_BYTES < MASK_BITS) m[b / SEC_BYTES] = 1'b1;
      return m;
   endfunction

   // apply one request word to the shadow table and return its result
   function automatic fat_result_type serve_request(kind_type k, logic [ENTRY_W-1:0] cl,
                                                    logic [ENTRY_W-1:0] val);
      fat_result_type     r;
      int                 top;
      int                 c;
      int                 steps;
      logic [ENTRY_W-1:0] nxt;
      r = PLAIN_OK;
      case (k)
         KIND_READ: r.entry = fat_shadow[cl];
         KIND_WRITE: fat_shadow[cl] = val;
         KIND_ALLOC: begin
            top = (limit_shadow > NUM_ENT) ? NUM_ENT : int'(limit_shadow);
            r.ok = 1'b0;
            for (int i = FIRST_DATA_CL; i < top; i++) begin
               if (fat_shadow[i] == FREE_ENTRY) begin
                  fat_shadow[i] = END_MARK;
                  r.entry = ENTRY_W'(i);
                  r.ok = 1'b1;
                  break;
               end
            end
         end
         KIND_FREE: begin
            c = cl;
            steps = 0;
            if (cl >= FIRST_DATA_CL) begin
               while (c < CHAIN_END_MIN && c < NUM_ENT) begin
                  if (steps >= NUM_ENT) begin
                     r.ok = 1'b0;
                     break;
                  end
                  nxt = fat_shadow[c];
                  fat_shadow[c] = FREE_ENTRY;
                  r.sector_mask |= sectors_touched(c);
                  steps++;
                  c = nxt;
               end
            end
         end
      endcase
      return r;
   endfunction

   // dry run of a free; true if the walk would run out of steps
   function automatic bit free_would_loop(logic [ENTRY_W-1:0] start);
      bit [ENTRY_W-1:0] saved [NUM_ENT];
      fat_result_type   r;
      saved = fat_shadow;
      r = serve_request(KIND_FREE, start, '0);
      fat_shadow = saved;
      return !r.ok;
   endfunction

   // offer one request word, log its expected result, then maybe idle
   task automatic issue_request(kind_type k, logic [ENTRY_W-1:0] cl, logic [ENTRY_W-1:0] val,
                                bit typed, fat_result_type fixed);
      fat_result_type r;
      // long walks are costly: only a few are let through
      if (k == KIND_FREE && free_would_loop(cl)) begin
         if (loop_budget > 0) loop_budget--;
         else k = KIND_READ;
      end
      req_valid   <= 1'b1;
      req_kind    <= k;
      req_cluster <= cl;
      req_value   <= val;
      do @(posedge clock); while (req_stall);
      r = serve_request(k, cl, val);
      pending_results.push_back(typed ? fixed : r);
      if (k == KIND_ALLOC && r.ok) owned_clusters.push_back(r.entry);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // csr write once the engine has drained
   task automatic set_alloc_limit(logic [LIMIT_W-1:0] limit);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_shadow = limit;
   endtask

   // compare one accepted result word with the oldest expectation
   task automatic check_result();
      fat_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result word: entry %h ok %b sector_mask %h",
                  $time, rsp_entry, rsp_ok, rsp_sector_mask);
         errors++;
      end else begin
         want = pending_results.pop_front();
         if (rsp_entry !== want.entry) begin
            $display("%0t: entry expected %h actual %h", $time, want.entry, rsp_entry);
            errors++;
         end
         if (rsp_ok !== want.ok) begin
            $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_ok);
            errors++;
         end
         if (rsp_sector_mask !== want.sector_mask) begin
            $display("%0t: sector_mask expected %h actual %h",
                     $time, want.sector_mask, rsp_sector_mask);
            errors++;
         end
      end
   endtask

   // result side: check words, drive stall in bursts or one long hold
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
      if (hold_token != hold_taken) begin
         hold_taken <= hold_token;
         stall_left <= LONG_HOLD;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= MAX_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type   row;
      logic [LIMIT_W-1:0] phase_limit [NUM_PHASES];
      logic [ENTRY_W-1:0] links [$];
      logic [ENTRY_W-1:0] nxt_val;
      int                 done;
      int                 pick;
      int                 len;
      int                 stride;
      int                 base;
      int                 idx;
      bit                 backward;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED[i];
         if (row.is_cfg) set_alloc_limit(row.data);
         else issue_request(row.kind, row.cluster, row.data[ENTRY_W-1:0], row.typed, row.want);
      end

      // random phases, one allocation limit each
      phase_limit = '{13'd4096, LIMIT_W'($urandom_range(3, 4096)), 13'd3, RESET_ALLOC_LIMIT};
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_alloc_limit(phase_limit[ph]);
         if (ph == 0) hold_token <= ~hold_token;
         done = 0;
         while (done < PHASE_ITEMS) begin
            if (ph == NUM_PHASES - 1 && done >= PHASE_ITEMS - CALM_ITEMS) calm <= 1'b1;
            pick = $urandom_range(0, 99);
            if (fat_shadow[0] < CHAIN_END_MIN && pick < 25) begin
               // put an end mark back in entry 0 so stray walks terminate
               issue_request(KIND_WRITE, '0, CHAIN_END_MIN | ENTRY_W'($urandom_range(0, 15)),
                             1'b0, '0);
               done++;
            end else if (pick < 40) begin
               // build a chain of distinct clusters, then free it
               len      = $urandom_range(1, 6);
               stride   = $urandom_range(1, 400);
               base     = $urandom_range(FIRST_DATA_CL, CHAIN_END_MIN - 1 - 5 * stride);
               backward = $urandom_range(0, 1);
               links.delete();
               for (int k = 0; k < len; k++)
                  links.push_back(ENTRY_W'(backward ? base + (len - 1 - k) * stride
                                                    : base + k * stride));
               for (int k = 0; k < len; k++) begin
                  nxt_val = (k == len - 1) ? (CHAIN_END_MIN | ENTRY_W'($urandom_range(0, 15)))
                                           : links[k + 1];
                  issue_request(KIND_WRITE, links[k], nxt_val, 1'b0, '0);
               end
               if ($urandom_range(0, 3) == 0) begin
                  issue_request(KIND_READ, links[0], ENTRY_W'($urandom), 1'b0, '0);
                  done++;
               end
               issue_request(KIND_FREE, links[0], ENTRY_W'($urandom), 1'b0, '0);
               done += len + 1;
            end else if (pick < 58 || (pick < 68 && owned_clusters.size() == 0)) begin
               issue_request(KIND_ALLOC, ENTRY_W'($urandom), ENTRY_W'($urandom), 1'b0, '0);
               done++;
            end else if (pick < 68) begin
               // release a cluster taken by an earlier allocation
               idx = $urandom_range(0, owned_clusters.size() - 1);
               issue_request(KIND_FREE, owned_clusters[idx], ENTRY_W'($urandom), 1'b0, '0);
               owned_clusters.delete(idx);
               done++;
            end else if (pick < 80) begin
               issue_request(KIND_READ, ENTRY_W'($urandom), ENTRY_W'($urandom), 1'b0, '0);
               done++;
            end else begin
               issue_request(kind_type'($urandom_range(0, 3)), ENTRY_W'($urandom),
                             ENTRY_W'($urandom), 1'b0, '0);
               done++;
            end
         end
      end

      // drain and report
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/fce_pkg.sv
hdl/fce_ram.sv
hdl/fce_sector.sv
hdl/fat12_cluster_chain_engine.sv
dv/tb_fat12_cluster_chain_engine.sv
